### design/rov_pkg.sv
// Shared types, codes and helpers for the replica output voter.
package rov_pkg;

	// Item kinds carried on the input side.
	localparam logic [1:0] CMD_HEADER = 2'd0;
	localparam logic [1:0] CMD_BEAT   = 2'd1;
	localparam logic [1:0] CMD_END    = 2'd2;

	// Fault kinds reported in the verdict.
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_LENGTH  = 2'd1;
	localparam logic [1:0] KIND_CONTENT = 2'd2;
	localparam logic [1:0] KIND_TIMEOUT = 2'd3;

	// Configuration register indexes.
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	localparam int NUM_LANES = 3;

	// Control strobes from the round tracker to every lane.
	typedef struct packed {
		logic header;
		logic beat;
		logic clear;
	} lane_ctl_t;

	// Per-lane comparison status against replica 0.
	typedef struct packed {
		logic len_ne;
		logic diff;
	} lane_stat_t;

	// Dual mode record: valid, content mismatch, blamed replica.
	typedef struct packed {
		logic valid;
		logic content;
		logic idx;
	} dual_flag_t;

	// Triple mode record: valid and blamed replica.
	typedef struct packed {
		logic       valid;
		logic [1:0] idx;
	} tri_flag_t;

	typedef struct packed {
		logic       fault;
		logic [1:0] kind;
		logic [1:0] faulty;
		logic [1:0] fwd;
	} verdict_t;

	// Majority blame from the a-b and a-c disagreement flags.
	function automatic logic [1:0] triple_blame(input logic ab, input logic ac);
		logic [1:0] r;
		if (ab) begin
			r = ac ? 2'd0 : 2'd1;
		end else begin
			r = 2'd2;
		end
		return r;
	endfunction

endpackage

### design/rov_lane.sv
// One replica lane: output score and comparison against replica 0.
module rov_lane import rov_pkg::*; #(
	parameter int SCORE_W = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctl_t          ctl,
	input  logic [12:0]        len_ref,
	input  logic [12:0]        len_own,
	input  logic [7:0]         byte_ref,
	input  logic [7:0]         byte_own,
	output logic [SCORE_W-1:0] score,
	output lane_stat_t         stat
);

	logic [SCORE_W-1:0] score_q;
	logic               diff_q;

	// Content difference seen so far in the open channel, including this beat.
	assign stat.len_ne = (len_own != len_ref);
	assign stat.diff   = diff_q | (byte_own != byte_ref);
	assign score       = score_q;

	// Score counts channels with output; the difference flag is per channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
			diff_q  <= 1'b0;
		end else if (ctl.clear) begin
			score_q <= '0;
			diff_q  <= 1'b0;
		end else if (ctl.header) begin
			if (len_own != 13'd0) begin
				score_q <= score_q + SCORE_W'(1);
			end
			diff_q <= 1'b0;
		end else if (ctl.beat) begin
			diff_q <= stat.diff;
		end
	end

endmodule

### design/rov_verdict.sv
// Merging stage: combines lane scores and round flags into the verdict.
module rov_verdict import rov_pkg::*; #(
	parameter int SCORE_W = 4
) (
	input  logic [1:0]         mode,
	input  logic [3:0]         chan_limit,
	input  logic               timed_out,
	input  logic [SCORE_W-1:0] score [NUM_LANES],
	input  dual_flag_t         dual_flag,
	input  tri_flag_t          tlen_flag,
	input  tri_flag_t          tcont_flag,
	output verdict_t           verdict
);

	logic [1:0] reps;
	logic [3:0] lowest;
	logic [1:0] idx;

	always_comb begin
		reps           = (mode == 2'd0) ? 2'd1 : mode;
		lowest         = chan_limit;
		idx            = 2'd0;
		verdict        = '0;
		// Timeout: fewest channels with output, lower index wins ties.
		for (int r = 0; r < NUM_LANES; r++) begin
			if ((2'(r) < reps) && (4'(score[r]) < lowest)) begin
				idx    = 2'(r);
				lowest = 4'(score[r]);
			end
		end
		if (timed_out) begin
			verdict.fault  = 1'b1;
			verdict.kind   = KIND_TIMEOUT;
			verdict.faulty = idx;
		end else if (reps == 2'd2) begin
			if (dual_flag.valid) begin
				verdict.fault  = 1'b1;
				verdict.kind   = dual_flag.content ? KIND_CONTENT : KIND_LENGTH;
				verdict.faulty = {1'b0, dual_flag.idx};
			end
		end else if (reps == 2'd3) begin
			if (tlen_flag.valid) begin
				verdict.fault  = 1'b1;
				verdict.kind   = KIND_LENGTH;
				verdict.faulty = tlen_flag.idx;
			end else if (tcont_flag.valid) begin
				verdict.fault  = 1'b1;
				verdict.kind   = KIND_CONTENT;
				verdict.faulty = tcont_flag.idx;
			end
		end
		// Forwarded replica is the previous one, cyclically.
		if (verdict.fault) begin
			case (reps)
				2'd2:    verdict.fwd = {1'b0, ~verdict.faulty[0]};
				2'd3:    verdict.fwd = (verdict.faulty == 2'd0) ? 2'd2 : verdict.faulty - 2'd1;
				default: verdict.fwd = 2'd0;
			endcase
		end
	end

endmodule

### design/replica_output_voter_unit.sv
// Top level of the replica output voter: round tracker, lanes and verdict register.
//
// Channel   Ports                          Transaction
// s_        s_tvalid s_tready s_tdata s_tuser   header, data beat or round end
// m_        m_tvalid m_tready m_tdata           one verdict per round end
// cfg_      cfg_we cfg_index cfg_wdata          register write
//
// Headers and beats add no stall of their own.
// A verdict appears in the output register the cycle after its round end.
// Input stalls only while a verdict waits and m_tready is low.
// Reset clears all round state and sets mode 3 and one channel.
module replica_output_voter_unit import rov_pkg::*; #(
	parameter int MAX_CHANNELS  = 8,
	parameter int MAX_BUF_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// len_a[12:0] len_b[25:13] len_c[38:26] byte_a[46:39] byte_b[54:47]
	// byte_c[62:55] timed_out[63]
	input  logic [63:0] s_tdata,
	// command[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// fault[0] fault_kind[2:1] faulty_replica[4:3] forward_replica[6:5] zero[7]
	output logic [7:0]  m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_wdata
);

	localparam int SCORE_W = $clog2(MAX_CHANNELS + 1);
	localparam int BEAT_W  = $clog2(MAX_BUF_BYTES + 1);

	logic [1:0]         mode_q;
	logic [3:0]         count_q;
	logic [SCORE_W-1:0] headers_q;
	logic [BEAT_W-1:0]  beats_q;
	logic               open_q;
	logic               len_eq_q;
	dual_flag_t         dual_q;
	tri_flag_t          tlen_q;
	tri_flag_t          tcont_q;
	logic               m_valid_q;
	verdict_t           out_q;

	logic [12:0]        len [NUM_LANES];
	logic [7:0]         bytes [NUM_LANES];
	logic               timed_out;
	logic               acc;
	logic [3:0]         chan_limit;
	logic               hdr_take;
	logic               beat_take;
	logic               end_take;
	lane_ctl_t          ctl;
	lane_stat_t         stat [NUM_LANES];
	logic [SCORE_W-1:0] score [NUM_LANES];
	logic [BEAT_W-1:0]  beats_init;
	verdict_t           verdict;

	// Field unpacking.
	assign len[0]    = s_tdata[12:0];
	assign len[1]    = s_tdata[25:13];
	assign len[2]    = s_tdata[38:26];
	assign bytes[0]  = s_tdata[46:39];
	assign bytes[1]  = s_tdata[54:47];
	assign bytes[2]  = s_tdata[62:55];
	assign timed_out = s_tdata[63];

	// Handshake and item decoding.
	assign s_tready   = ~m_valid_q | m_tready;
	assign acc        = s_tvalid & s_tready;
	assign chan_limit = (count_q > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : count_q;
	assign hdr_take   = acc && (s_tuser == CMD_HEADER) && (4'(headers_q) < chan_limit);
	assign beat_take  = acc && (s_tuser == CMD_BEAT) && open_q;
	assign end_take   = acc && (s_tuser == CMD_END);
	assign ctl        = '{header: hdr_take, beat: beat_take, clear: end_take};

	// Beats expected for a channel are capped at the buffer size.
	assign beats_init = ({19'd0, len[0]} > 32'(MAX_BUF_BYTES)) ?
		BEAT_W'(MAX_BUF_BYTES) : BEAT_W'(len[0]);

	// Replica lanes.
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		rov_lane #(.SCORE_W(SCORE_W)) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.len_ref  (len[0]),
			.len_own  (len[g]),
			.byte_ref (bytes[0]),
			.byte_own (bytes[g]),
			.score    (score[g]),
			.stat     (stat[g])
		);
	end

	rov_verdict #(.SCORE_W(SCORE_W)) u_verdict (
		.mode       (mode_q),
		.chan_limit (chan_limit),
		.timed_out  (timed_out),
		.score      (score),
		.dual_flag  (dual_q),
		.tlen_flag  (tlen_q),
		.tcont_flag (tcont_q),
		.verdict    (verdict)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 2'd3;
			count_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:  mode_q  <= cfg_wdata[1:0];
				REG_COUNT: count_q <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	// Round tracker and fault records.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			headers_q <= '0;
			beats_q   <= '0;
			open_q    <= 1'b0;
			len_eq_q  <= 1'b0;
			dual_q    <= '0;
			tlen_q    <= '0;
			tcont_q   <= '0;
		end else if (end_take) begin
			headers_q <= '0;
			beats_q   <= '0;
			open_q    <= 1'b0;
			len_eq_q  <= 1'b0;
			dual_q    <= '0;
			tlen_q    <= '0;
			tcont_q   <= '0;
		end else if (hdr_take) begin
			headers_q <= headers_q + SCORE_W'(1);
			len_eq_q  <= ~stat[1].len_ne;
			if (stat[1].len_ne) begin
				dual_q <= '{valid: 1'b1, content: 1'b0, idx: ~(len[0] < len[1])};
			end
			if (stat[1].len_ne || stat[2].len_ne) begin
				tlen_q <= '{valid: 1'b1, idx: triple_blame(stat[1].len_ne, stat[2].len_ne)};
			end
			beats_q <= beats_init;
			open_q  <= (beats_init != '0);
		end else if (beat_take) begin
			if (stat[1].diff || stat[2].diff) begin
				tcont_q <= '{valid: 1'b1, idx: triple_blame(stat[1].diff, stat[2].diff)};
			end
			if (stat[1].diff && len_eq_q) begin
				dual_q <= '{valid: 1'b1, content: 1'b1, idx: 1'b0};
			end
			beats_q <= beats_q - BEAT_W'(1);
			if (beats_q == BEAT_W'(1)) begin
				open_q <= 1'b0;
			end
		end
	end

	// Verdict output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (end_take) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_take) begin
			out_q <= verdict;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, out_q.fwd, out_q.faulty, out_q.kind, out_q.fault};

endmodule

### design/rov_checker.sv
// Port-level checks for the replica output voter, bound to the top level.
module rov_checker import rov_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// A stalled verdict holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("verdict changed while stalled");

	// Every accepted round end yields a verdict in the next cycle.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_END) |=> m_tvalid)
		else $error("round end gave no verdict");

	// A clean verdict carries no kind and no replica indexes.
	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[7:1] == 7'd0))
		else $error("clean verdict has nonzero fields");

	// A fault always has a kind and a valid replica index.
	a_fault_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> (m_tdata[2:1] != KIND_NONE) && (m_tdata[4:3] != 2'd3)
			&& (m_tdata[6:5] != 2'd3))
		else $error("fault verdict malformed");

endmodule

bind replica_output_voter_unit rov_checker u_rov_checker (.*);

### tb/sv/tb_top.sv
// Self-checking testbench for the replica output voter: stimulus, verdict prediction and checks.
`timescale 1ns / 1ps

module tb_top import rov_pkg::*;;

	localparam int CHAN_MAX = 8;
	localparam int BUF_MAX  = 4096;
	// The block ignores this item kind; it is sent only as noise.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Tracks one voting round and predicts the verdict of each round end.
	class verdict_tracker;
		logic [1:0]  mode;
		logic [3:0]  chans;
		logic        open;
		logic        lens_equal;
		logic [1:0]  differs;
		dual_flag_t  dual;
		tri_flag_t   len_vote;
		tri_flag_t   content_vote;
		logic [3:0]  score [3];
		int unsigned headers;
		int unsigned beats_left;
		verdict_t    pending_verdicts [$];
		int          errors;

		function new();
			mode = 2'd3;
			chans = 4'd1;
			errors = 0;
			clear_round();
		endfunction

		function void clear_round();
			open = 1'b0;
			lens_equal = 1'b0;
			differs = 2'b00;
			dual = '0;
			len_vote = '0;
			content_vote = '0;
			for (int r = 0; r < 3; r++) score[r] = 4'd0;
			headers = 0;
			beats_left = 0;
		endfunction

		function int unsigned chan_limit();
			return (chans > CHAN_MAX) ? CHAN_MAX : chans;
		endfunction

		// Replica in the minority, from the a-b and a-c disagreement flags.
		function logic [1:0] outlier(logic ab, logic ac);
			if (ab && ac) return 2'd0;
			if (ab) return 2'd1;
			return 2'd2;
		endfunction

		function void set_register(logic idx, logic [3:0] val);
			if (idx == REG_MODE) mode = val[1:0];
			else chans = val;
		endfunction

		function int pending();
			return pending_verdicts.size();
		endfunction

		// Updates the round state for one accepted input transaction.
		function void note_item(logic [1:0] cmd, logic [63:0] d);
			logic [12:0] la, lb, lc;
			logic [7:0]  ba, bb, bc;
			verdict_t    v;
			int unsigned reps, lowest;
			la = d[12:0];
			lb = d[25:13];
			lc = d[38:26];
			ba = d[46:39];
			bb = d[54:47];
			bc = d[62:55];
			case (cmd)
				CMD_HEADER: begin
					if (headers >= chan_limit()) return;
					headers++;
					if (la != 0) score[0]++;
					if (lb != 0) score[1]++;
					if (lc != 0) score[2]++;
					lens_equal = (la == lb);
					differs = 2'b00;
					if (la != lb) dual = '{valid: 1'b1, content: 1'b0, idx: (la >= lb)};
					if (la != lb || la != lc)
						len_vote = '{valid: 1'b1, idx: outlier(la != lb, la != lc)};
					beats_left = (la > BUF_MAX) ? BUF_MAX : la;
					open = (beats_left != 0);
				end
				CMD_BEAT: begin
					if (!open) return;
					if (ba != bb) differs[0] = 1'b1;
					if (ba != bc) differs[1] = 1'b1;
					if (differs != 2'b00)
						content_vote = '{valid: 1'b1, idx: outlier(differs[0], differs[1])};
					if (differs[0] && lens_equal)
						dual = '{valid: 1'b1, content: 1'b1, idx: 1'b0};
					beats_left--;
					if (beats_left == 0) open = 1'b0;
				end
				CMD_END: begin
					reps = (mode == 2'd0) ? 1 : mode;
					v = '0;
					if (d[63]) begin
						// The replica with the fewest channels holding output is blamed.
						lowest = chan_limit();
						v.fault = 1'b1;
						v.kind = KIND_TIMEOUT;
						for (int r = 0; r < reps; r++) begin
							if (score[r] < lowest) begin
								v.faulty = 2'(r);
								lowest = 32'(score[r]);
							end
						end
					end else if (reps == 2) begin
						if (dual.valid) begin
							v.fault = 1'b1;
							v.kind = dual.content ? KIND_CONTENT : KIND_LENGTH;
							v.faulty = {1'b0, dual.idx};
						end
					end else if (reps == 3) begin
						if (len_vote.valid) begin
							v.fault = 1'b1;
							v.kind = KIND_LENGTH;
							v.faulty = len_vote.idx;
						end else if (content_vote.valid) begin
							v.fault = 1'b1;
							v.kind = KIND_CONTENT;
							v.faulty = content_vote.idx;
						end
					end
					if (v.fault) v.fwd = 2'((v.faulty + reps - 1) % reps);
					pending_verdicts.push_back(v);
					clear_round();
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [1:0] want, logic [1:0] got);
			if (got !== want) begin
				$error("verdict field %s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// Compares one accepted verdict with the oldest prediction.
		function void check_verdict(logic [7:0] d);
			verdict_t want, got;
			if (pending_verdicts.size() == 0) begin
				$error("verdict %h arrived with none predicted", d);
				errors++;
				return;
			end
			want = pending_verdicts.pop_front();
			got.fault = d[0];
			got.kind = d[2:1];
			got.faulty = d[4:3];
			got.fwd = d[6:5];
			compare_field("fault", {1'b0, want.fault}, {1'b0, got.fault});
			compare_field("fault_kind", want.kind, got.kind);
			compare_field("faulty_replica", want.faulty, got.faulty);
			compare_field("forward_replica", want.fwd, got.fwd);
			compare_field("padding", 2'd0, {1'b0, d[7]});
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// len_a[12:0] len_b[25:13] len_c[38:26] byte_a[46:39] byte_b[54:47]
	// byte_c[62:55] timed_out[63]
	logic [63:0] s_tdata;
	// command[1:0]
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// fault[0] fault_kind[2:1] faulty_replica[4:3] forward_replica[6:5] zero[7]
	logic [7:0]  m_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [3:0]  cfg_wdata;

	verdict_tracker sb = new();
	int          tx_idle = 0;
	int          rx_stall = 0;
	int          hold_left = 0;
	int unsigned cur_count = 1;
	int unsigned items_sent = 0;

	replica_output_voter_unit #(
		.MAX_CHANNELS(CHAN_MAX),
		.MAX_BUF_BYTES(BUF_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// Watch both sides; every transaction is seen with its pre-edge values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
		end
	end

	// Verdict receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall);
			end
		end
	end

	// Offers one input transaction after random idle cycles and waits for it to be taken.
	task automatic send(input logic [1:0] cmd, input logic [63:0] d);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			s_tuser <= 2'($urandom);
			s_tdata <= {$urandom, $urandom};
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	function automatic logic [63:0] item_bits(logic [12:0] la, logic [12:0] lb,
			logic [12:0] lc, logic [7:0] ba, logic [7:0] bb, logic [7:0] bc, logic to);
		return {to, bc, bb, ba, lc, lb, la};
	endfunction

	task automatic send_header(input logic [12:0] la, input logic [12:0] lb,
			input logic [12:0] lc);
		send(CMD_HEADER, item_bits(la, lb, lc, 8'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom)));
	endtask

	task automatic send_beat(input logic [7:0] ba, input logic [7:0] bb, input logic [7:0] bc);
		send(CMD_BEAT, item_bits(13'($urandom), 13'($urandom), 13'($urandom), ba, bb, bc,
			1'($urandom)));
	endtask

	task automatic send_end(input logic to);
		send(CMD_END, item_bits(13'($urandom), 13'($urandom), 13'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), to));
	endtask

	task automatic send_noise();
		send(CMD_UNUSED, {$urandom, $urandom});
	endtask

	// Stops offering input and waits until every predicted verdict has arrived.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes both registers while the block is idle.
	task automatic set_config(input logic [3:0] mode_val, input logic [3:0] count_val);
		cfg_we <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_wdata <= mode_val;
		@(posedge clk);
		sb.set_register(REG_MODE, mode_val);
		cfg_index <= REG_COUNT;
		cfg_wdata <= count_val;
		@(posedge clk);
		sb.set_register(REG_COUNT, count_val);
		cur_count = count_val;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly short lengths, now and then any 13-bit value.
	function automatic logic [12:0] pick_len();
		if ($urandom_range(99) < 6) return 13'($urandom_range(8191));
		return 13'($urandom_range(5));
	endfunction

	// One well-formed round with random content and occasional breaks in the sequence.
	task automatic random_round();
		int unsigned nch, nb, ch, k, roll;
		logic [12:0] la, lb, lc;
		logic [7:0]  b;
		nch = (cur_count > CHAN_MAX) ? CHAN_MAX : cur_count;
		roll = $urandom_range(9);
		if (roll == 0) nch++;
		else if (roll == 1 && nch > 0) nch--;
		for (ch = 0; ch < nch; ch++) begin
			la = pick_len();
			lb = la;
			lc = la;
			roll = $urandom_range(99);
			if (roll < 10) lb = pick_len();
			else if (roll < 20) lc = pick_len();
			else if (roll < 25) begin
				lb = pick_len();
				lc = pick_len();
			end
			send_header(la, lb, lc);
			// Long channels get only a few beats and are cut short by the next item.
			nb = (la > 8) ? $urandom_range(4) : la;
			roll = $urandom_range(99);
			if (roll < 8 && nb > 0) nb--;
			else if (roll < 14) nb++;
			for (k = 0; k < nb; k++) begin
				b = 8'($urandom);
				roll = $urandom_range(99);
				if (roll < 5) send_beat(b, 8'($urandom), b);
				else if (roll < 10) send_beat(b, b, 8'($urandom));
				else if (roll < 12) send_beat(b, 8'($urandom), 8'($urandom));
				else if (roll < 14) send_beat(8'($urandom), b, b);
				else send_beat(b, b, b);
			end
			if ($urandom_range(49) == 0) send_noise();
		end
		send_end($urandom_range(99) < 20);
	endtask

	// Run limit.
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Main sequence.
	initial begin
		logic [3:0]  mode_tab  [9];
		logic [3:0]  count_tab [9];
		int          tx_tab    [9];
		int          rx_tab    [9];
		int unsigned start;

		mode_tab  = '{4'd2, 4'd3, 4'd1, 4'd3, 4'hC, 4'd2, 4'h7, 4'd3, 4'hE};
		count_tab = '{4'd8, 4'd3, 4'd2, 4'd8, 4'd1, 4'd15, 4'd0, 4'd1, 4'd4};
		tx_tab    = '{0, 76, 0, 26, 26, 76, 0, 0, 0};
		rx_tab    = '{0, 0, 76, 26, 26, 0, 76, 0, 0};

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= CMD_HEADER;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_wdata <= 4'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, triple mode with one channel: content minority,
		// surplus header, ignored command, stray beat, timeout with nothing output.
		send_header(13'd2, 13'd2, 13'd2);
		send_beat(8'h00, 8'h00, 8'h00);
		send_beat(8'hFF, 8'hFF, 8'h5A);
		send_end(1'b0);
		send_header(13'd1, 13'd1, 13'd1);
		send_header(13'd7, 13'd0, 13'd3);
		send_beat(8'h33, 8'h33, 8'h33);
		send_noise();
		send_end(1'b0);
		send_beat(8'h01, 8'h02, 8'h03);
		send_end(1'b1);
		settle();

		// Dual mode: content fault, then an early header with extreme lengths.
		set_config(4'd2, 4'd2);
		send_header(13'd3, 13'd3, 13'd0);
		send_beat(8'h01, 8'h02, 8'h01);
		send_header(13'd8191, 13'd4096, 13'd0);
		send_beat(8'h09, 8'h09, 8'h09);
		send_end(1'b0);
		send_header(13'd4, 13'd4, 13'd4);
		send_beat(8'h01, 8'h01, 8'h01);
		send_end(1'b1);
		settle();

		// Mode zero acts as single mode; a channel count of zero takes no header.
		set_config(4'd0, 4'd0);
		send_header(13'd5, 13'd5, 13'd5);
		send_end(1'b1);
		send_end(1'b0);
		settle();

		// Channel count above the maximum; timeout blame by score; length minority.
		set_config(4'd3, 4'd15);
		send_header(13'd1, 13'd0, 13'd1);
		send_header(13'd2, 13'd2, 13'd0);
		send_end(1'b1);
		send_header(13'd5, 13'd5, 13'd6);
		send_end(1'b0);
		settle();

		// Random rounds under several settings and idle patterns.
		for (int p = 0; p < 9; p++) begin
			set_config(mode_tab[p], count_tab[p]);
			tx_idle = tx_tab[p];
			rx_stall = rx_tab[p];
			// Long receiver hold-off so that a waiting verdict stalls the input.
			if (p == 7) hold_left = 300;
			start = items_sent;
			while (items_sent - start < 36) random_round();
			settle();
		end

		rx_stall = 0;
		settle();
		repeat (16) @(posedge clk);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
